// File: design/aes_pkg.sv
// AES-128 package: S-box table, GF(2^8) helpers and round transforms.
// Used by the round cell and the top level; depends on nothing.
package aes_pkg;

  typedef logic [127:0] blk_t;

  localparam int NumRounds = 10;
  localparam logic [7:0] RconInit = 8'h01;
  localparam logic [7:0] GfPoly = 8'h1b;
  localparam logic [7:0] RegKeyHi = 8'd0;
  localparam logic [7:0] RegKeyLo = 8'd1;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? GfPoly : 8'h00);
  endfunction

  // Byte i sits at bits [127-8i -: 8], so byte 0 is the most significant.
  function automatic logic [7:0] get_byte(input blk_t b, input int i);
    return b[127 - 8 * i -: 8];
  endfunction

  function automatic blk_t sub_shift(input blk_t s);
    blk_t t;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127 - 8 * (r + 4 * c) -: 8] = SBOX[get_byte(s, r + 4 * ((c + r) % 4))];
      end
    end
    return t;
  endfunction

  function automatic blk_t mix_columns(input blk_t s);
    blk_t t;
    logic [7:0] a0, a1, a2, a3, b0, b1, b2, b3;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4 * c);
      a1 = get_byte(s, 4 * c + 1);
      a2 = get_byte(s, 4 * c + 2);
      a3 = get_byte(s, 4 * c + 3);
      b0 = xtime(a0);
      b1 = xtime(a1);
      b2 = xtime(a2);
      b3 = xtime(a3);
      t[127 - 32 * c -: 8] = b0 ^ a1 ^ b1 ^ a2 ^ a3;
      t[119 - 32 * c -: 8] = a0 ^ b1 ^ a2 ^ b2 ^ a3;
      t[111 - 32 * c -: 8] = a0 ^ a1 ^ b2 ^ a3 ^ b3;
      t[103 - 32 * c -: 8] = a0 ^ b0 ^ a1 ^ a2 ^ b3;
    end
    return t;
  endfunction

  function automatic blk_t next_key(input blk_t k, input logic [7:0] rcon);
    logic [31:0] t;
    logic [31:0] w0, w1, w2, w3;
    t = {SBOX[k[23:16]] ^ rcon, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

// File: design/aes_if.sv
// Valid/ready channel interfaces for the AES block: data, result and key write.
// Depends on nothing.
interface aes_in_if;
  logic valid;
  logic ready;
  logic [63:0] data_hi;
  logic [63:0] data_lo;
  modport source (output valid, data_hi, data_lo, input ready);
  modport sink (input valid, data_hi, data_lo, output ready);
endinterface

interface aes_out_if;
  logic valid;
  logic ready;
  logic [63:0] cipher_hi;
  logic [63:0] cipher_lo;
  modport source (output valid, cipher_hi, cipher_lo, input ready);
  modport sink (input valid, cipher_hi, cipher_lo, output ready);
endinterface

interface aes_cfg_if;
  logic valid;
  logic ready;
  logic [7:0] index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/aes_round_cell.sv
// One AES round cell: registers state, round key and rcon, passes them on.
// Depends on aes_pkg.
module aes_round_cell
  import aes_pkg::*;
#(
  parameter bit LastRound = 1'b0
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  blk_t       in_state,
  input  blk_t       in_key,
  input  logic [7:0] in_rcon,
  output logic       out_valid,
  output blk_t       out_state,
  output blk_t       out_key,
  output logic [7:0] out_rcon
);

  blk_t ss;
  blk_t rk;

  always_comb begin
    ss = sub_shift(in_state);
    if (!LastRound) ss = mix_columns(ss);
    rk = next_key(in_key, in_rcon);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_state <= ss ^ rk;
      out_key <= rk;
      out_rcon <= xtime(in_rcon);
    end
  end

endmodule

// File: design/aes128_block_encrypt_top.sv
// AES-128 encryption top level: key registers, ten-cell round chain, skid output.
// Depends on aes_pkg, the channel interfaces and aes_round_cell.
//
// Usage: write the key on cfg (index 0 = key bytes 0..7, index 1 = bytes 8..15)
// while the block is idle; each write is one beat and is always taken. Writes
// to any other index are ignored.
// Each plaintext beat on in yields exactly one ciphertext beat on out, in order.
// The initial AddRoundKey is registered at the accept edge, then ten round cells
// follow, each one register stage; the result reaches out from the last of them.
// Throughput is one block per cycle: the chain advances every cycle that its
// last stage is empty or a skid register can take its result.
// When out stalls, the skid register holds one result; the chain freezes once
// its tail holds another; in.ready falls only while the whole chain is held.
// Reset clears the key registers to zero and all valid bits; the chain's
// payload registers are not reset.
module aes128_block_encrypt_top
  import aes_pkg::*;
(
  input logic clk,
  input logic rst,
  aes_cfg_if.sink cfg,
  aes_in_if.sink in,
  aes_out_if.source out
);

  logic [63:0] key_hi;
  logic [63:0] key_lo;
  logic en;
  logic v [NumRounds + 1];
  blk_t st [NumRounds + 1];
  blk_t ky [NumRounds + 1];
  logic [7:0] rc [NumRounds + 1];
  logic skid_valid;
  blk_t skid;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_hi <= '0;
      key_lo <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        RegKeyHi: key_hi <= cfg.data;
        RegKeyLo: key_lo <= cfg.data;
        default: ;
      endcase
    end
  end

  // The chain moves unless its tail holds a result and the skid is full.
  assign en = !(v[NumRounds] && skid_valid);
  assign in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in.valid;
    end
    if (en) begin
      st[0] <= {in.data_hi, in.data_lo} ^ {key_hi, key_lo};
      ky[0] <= {key_hi, key_lo};
      rc[0] <= RconInit;
    end
  end

  for (genvar g = 0; g < NumRounds; g++) begin : g_round
    aes_round_cell #(.LastRound(g == NumRounds - 1)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(v[g]), .in_state(st[g]), .in_key(ky[g]), .in_rcon(rc[g]),
      .out_valid(v[g + 1]), .out_state(st[g + 1]), .out_key(ky[g + 1]),
      .out_rcon(rc[g + 1])
    );
  end

  // Skid: the tail result is shown directly; if out stalls, it is caught here.
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out.ready) skid_valid <= 1'b0;
    end else if (v[NumRounds] && !out.ready) begin
      skid_valid <= 1'b1;
    end
    if (!skid_valid) skid <= st[NumRounds];
  end

  assign out.valid = skid_valid || v[NumRounds];
  assign out.cipher_hi = skid_valid ? skid[127:64] : st[NumRounds][127:64];
  assign out.cipher_lo = skid_valid ? skid[63:0] : st[NumRounds][63:0];

endmodule
